// ===== src/alfs_pkg.sv =====
package alfs_pkg;

  // Line geometry
  localparam int LINE_LIMIT = 256;
  localparam int COL_W      = $clog2(LINE_LIMIT + 1);

  // Field widths
  localparam int CH_W     = 8;
  localparam int FIELD_W  = 2;
  localparam int LMAX_W   = 6;
  // counter reaches 64 with a limit of 63 and a leading '='
  localparam int CNT_W    = 7;
  localparam int PHASE_W  = 3;

  localparam logic [LMAX_W-1:0] LABEL_MAX_RST = 6'd8;
  localparam logic [CNT_W-1:0]  MNEMO_MAX     = 7'd6;

  // Characters of interest
  localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CH_W-1:0] CH_EQ    = 8'h3D;
  localparam logic [CH_W-1:0] CH_LC_A  = 8'h61;
  localparam logic [CH_W-1:0] CH_LC_Z  = 8'h7A;
  localparam logic [CH_W-1:0] CASE_OFS = 8'h20;

  // Line phase codes
  localparam logic [PHASE_W-1:0] PH_START  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_SPACE0 = 3'd1;
  localparam logic [PHASE_W-1:0] PH_LABEL  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_SEEKMN = 3'd3;
  localparam logic [PHASE_W-1:0] PH_MNEMO  = 3'd4;
  localparam logic [PHASE_W-1:0] PH_SEEKMD = 3'd5;
  localparam logic [PHASE_W-1:0] PH_MODIF  = 3'd6;
  localparam logic [PHASE_W-1:0] PH_DONE   = 3'd7;

  // Output field tags
  localparam logic [FIELD_W-1:0] F_LABEL = 2'd0;
  localparam logic [FIELD_W-1:0] F_MNEMO = 2'd1;
  localparam logic [FIELD_W-1:0] F_MODIF = 2'd2;
  localparam logic [FIELD_W-1:0] F_EOL   = 2'd3;

  function automatic logic is_blank(input logic [CH_W-1:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  function automatic logic [CH_W-1:0] to_upper(input logic [CH_W-1:0] c);
    return ((c >= CH_LC_A) && (c <= CH_LC_Z)) ? (c - CASE_OFS) : c;
  endfunction

endpackage

// ===== src/assembler_line_field_splitter.sv =====
// Result: registered; an input transfer's result is on out_valid in the next cycle.
// Throughput: one byte per cycle; the only hold-off is a full result register
// under out_stall, which stalls the input in the same cycle.
// Reset (rst_n low, synchronous): start of line, column and counters cleared,
// label limit back to 8, result register empty.
module assembler_line_field_splitter
  import alfs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // byte input
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CH_W-1:0]    in_ch,
  // tagged result
  output logic               out_valid,
  input  logic               out_stall,
  output logic [FIELD_W-1:0] out_field,
  output logic [CH_W-1:0]    out_char,
  // label limit register
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LMAX_W-1:0]  cfg_label_max
);

  logic [LMAX_W-1:0]  label_max_r;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [COL_W-1:0]   column_r, column_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               extra_r, extra_nxt;

  logic               out_valid_r;
  logic [FIELD_W-1:0] out_field_r;
  logic [CH_W-1:0]    out_char_r;

  logic               emit;
  logic [FIELD_W-1:0] emit_field;
  logic [CH_W-1:0]    emit_char;
  logic               in_xfer;
  logic               label_room;
  logic               label_room_first;
  logic               mnemo_room;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall;
  assign in_xfer   = in_valid && !in_stall;

  // Truncation limits
  assign label_room       = count_r < ({1'b0, label_max_r} + {{LMAX_W{1'b0}}, extra_r});
  assign label_room_first = ({1'b0, label_max_r} + {{LMAX_W{1'b0}}, in_ch == CH_EQ})
                            != '0;
  assign mnemo_room       = count_r < MNEMO_MAX;

  // Phase update and emit decision for one byte
  always_comb begin
    phase_nxt  = phase_r;
    column_nxt = column_r;
    count_nxt  = count_r;
    extra_nxt  = extra_r;
    emit       = 1'b0;
    emit_field = F_LABEL;
    emit_char  = in_ch;
    if (in_ch == CH_NL) begin
      phase_nxt  = PH_START;
      column_nxt = '0;
      count_nxt  = '0;
      extra_nxt  = 1'b0;
      emit       = 1'b1;
      emit_field = F_EOL;
      emit_char  = CH_NUL;
    end else if (column_r < COL_W'(LINE_LIMIT)) begin
      column_nxt = column_r + COL_W'(1);
      if (in_ch == CH_NUL) begin
        phase_nxt = PH_DONE;
      end else begin
        case (phase_r)
          PH_START, PH_SPACE0: begin
            if (phase_r == PH_START && in_ch == CH_SPACE) begin
              phase_nxt = PH_SPACE0;
            end else if (is_blank(in_ch)) begin
              phase_nxt = PH_SEEKMN;
            end else if (in_ch == CH_STAR) begin
              phase_nxt = PH_DONE;
            end else begin
              // label starts here
              phase_nxt = PH_LABEL;
              extra_nxt = (in_ch == CH_EQ);
              count_nxt = label_room_first ? CNT_W'(1) : '0;
              emit      = label_room_first;
            end
          end
          PH_LABEL: begin
            if (is_blank(in_ch)) begin
              phase_nxt = PH_SEEKMN;
            end else if (label_room) begin
              count_nxt = count_r + CNT_W'(1);
              emit      = 1'b1;
            end
          end
          PH_SEEKMN: begin
            if (in_ch == CH_STAR) begin
              phase_nxt = PH_DONE;
            end else if (!is_blank(in_ch)) begin
              phase_nxt  = PH_MNEMO;
              count_nxt  = CNT_W'(1);
              emit       = 1'b1;
              emit_field = F_MNEMO;
              emit_char  = to_upper(in_ch);
            end
          end
          PH_MNEMO: begin
            if (is_blank(in_ch)) begin
              phase_nxt = PH_SEEKMD;
            end else if (mnemo_room) begin
              count_nxt  = count_r + CNT_W'(1);
              emit       = 1'b1;
              emit_field = F_MNEMO;
              emit_char  = to_upper(in_ch);
            end
          end
          PH_SEEKMD: begin
            if (!is_blank(in_ch)) begin
              phase_nxt  = PH_MODIF;
              emit       = 1'b1;
              emit_field = F_MODIF;
            end
          end
          PH_MODIF: begin
            emit       = 1'b1;
            emit_field = F_MODIF;
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
    end
  end

  // Line state and label limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      label_max_r <= LABEL_MAX_RST;
      phase_r     <= PH_START;
      column_r    <= '0;
      count_r     <= '0;
      extra_r     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        label_max_r <= cfg_label_max;
      end
      if (in_xfer) begin
        phase_r  <= phase_nxt;
        column_r <= column_nxt;
        count_r  <= count_nxt;
        extra_r  <= extra_nxt;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer && emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && emit) begin
      out_field_r <= emit_field;
      out_char_r  <= emit_char;
    end
  end

  assign out_valid = out_valid_r;
  assign out_field = out_field_r;
  assign out_char  = out_char_r;

  // Checks
  a_nl_gives_eol: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_ch == CH_NL |=> out_valid && out_field == F_EOL && out_char == CH_NUL)
    else $error("newline did not yield end-of-line marker");

  a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && phase_r == PH_DONE && in_ch != CH_NL |=> !out_valid)
    else $error("output after line content ended");

  a_mnemo_upper: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_field == F_MNEMO |-> !(out_char >= CH_LC_A && out_char <= CH_LC_Z))
    else $error("lower-case mnemonic character");

  a_column_bound: assert property (@(posedge clk) disable iff (!rst_n)
    column_r <= COL_W'(LINE_LIMIT))
    else $error("column beyond line limit");

  a_mnemo_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_MNEMO |-> count_r <= MNEMO_MAX)
    else $error("mnemonic count beyond six");

endmodule
